// ===== hw/rtl/hcd_pkg.sv =====
// Shared types, codes and small decode functions for the host command deframer.
// No dependencies; every other file of the block imports this package.
package hcd_pkg;

  // Command byte values on the wire.
  localparam logic [7:0] CMD_BYTE_SEND    = 8'h01;
  localparam logic [7:0] CMD_BYTE_CONFIG  = 8'h02;
  localparam logic [7:0] CMD_BYTE_DISPLAY = 8'h03;

  // Config tag characters.
  localparam logic [7:0] TAG_UPPER_T = 8'h54;  // 'T'
  localparam logic [7:0] TAG_UPPER_C = 8'h43;  // 'C'
  localparam logic [7:0] TAG_UPPER_R = 8'h52;  // 'R'
  localparam logic [7:0] TAG_LOWER_C = 8'h63;  // 'c'

  // Minimum body lengths of the config frames.
  localparam int unsigned SETTINGS_MIN_LEN = 20;
  localparam int unsigned RETUNE_MIN_LEN   = 6;

  // Number of leading body bytes kept for config decode.
  localparam int unsigned HEAD_DEPTH = 16;

  // Bandwidth values in kHz.
  localparam logic [8:0] BW_125 = 9'd125;
  localparam logic [8:0] BW_250 = 9'd250;
  localparam logic [8:0] BW_500 = 9'd500;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Command held for the current frame.
  typedef enum logic [1:0] {
    FRAME_NONE    = 2'd0,
    FRAME_SEND    = 2'd1,
    FRAME_CONFIG  = 2'd2,
    FRAME_DISPLAY = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_SEND      = 3'd0,
    KIND_DISPLAY   = 3'd1,
    KIND_TX_SET    = 3'd2,
    KIND_RX_SET    = 3'd3,
    KIND_TX_RETUNE = 3'd4
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data_byte;
    logic [8:0]        byte_index;
    logic              last_byte;
    logic [31:0]       freq_hz;
    logic signed [7:0] tx_power;
    logic [8:0]        bandwidth_khz;
    logic [7:0]        spread_factor;
    logic [3:0]        coding_rate;
    logic [7:0]        preamble_len;
    logic              crc_enable;
  } result_t;

  // Bandwidth code to kHz.
  function automatic logic [8:0] bw_of(input logic [7:0] code);
    logic [8:0] bw;
    case (code)
      8'd1:    bw = BW_250;
      8'd2:    bw = BW_500;
      default: bw = BW_125;
    endcase
    return bw;
  endfunction

  // Coding rate code 1..4 maps to 5..8; anything else gives 5.
  function automatic logic [3:0] cr_of(input logic [7:0] code);
    logic [3:0] cr;
    if (code >= 8'd1 && code <= 8'd4) begin
      cr = code[3:0] + 4'd4;
    end else begin
      cr = 4'd5;
    end
    return cr;
  endfunction

endpackage

// ===== hw/rtl/hcd_cfg_decode.sv =====
// Config frame decoder: turns the leading body bytes of a config frame into one
// settings result. Depends on hcd_pkg.
module hcd_cfg_decode #(
  parameter int unsigned LEN_W = 9
) (
  input  logic [7:0]       head [hcd_pkg::HEAD_DEPTH],
  input  logic [LEN_W-1:0] body_length,
  output logic             valid,
  output hcd_pkg::result_t res
);
  import hcd_pkg::*;

  logic [16:0] len_ext;
  logic        long_enough;
  logic        retune_ok;
  logic [31:0] freq;

  assign len_ext     = 17'(body_length);
  assign long_enough = len_ext >= 17'(SETTINGS_MIN_LEN);
  assign retune_ok   = len_ext >= 17'(RETUNE_MIN_LEN);
  assign freq        = {head[5], head[4], head[3], head[2]};

  // Match the two tag bytes and fill the settings fields.
  always_comb begin
    res   = '0;
    valid = 1'b0;
    if (head[0] == TAG_UPPER_T && head[1] == TAG_UPPER_C && long_enough) begin
      valid             = 1'b1;
      res.kind          = KIND_TX_SET;
      res.freq_hz       = freq;
      res.tx_power      = head[7];
      res.bandwidth_khz = bw_of(head[9]);
      res.spread_factor = head[10];
      res.coding_rate   = cr_of(head[11]);
      res.preamble_len  = head[12];
      res.crc_enable    = head[14] != 8'd0;
    end else if (head[0] == TAG_UPPER_R && head[1] == TAG_UPPER_C && long_enough) begin
      valid             = 1'b1;
      res.kind          = KIND_RX_SET;
      res.freq_hz       = freq;
      res.bandwidth_khz = bw_of(head[7]);
      res.spread_factor = head[8];
      res.coding_rate   = cr_of(head[9]);
      res.preamble_len  = head[11];
      res.crc_enable    = head[15] != 8'd0;
    end else if (head[0] == TAG_UPPER_T && head[1] == TAG_LOWER_C && retune_ok) begin
      valid       = 1'b1;
      res.kind    = KIND_TX_RETUNE;
      res.freq_hz = freq;
    end
  end

endmodule

// ===== hw/rtl/hcd_parser.sv =====
// Frame parser: command, length and body tracking, head byte capture and result
// generation for one accepted byte. Depends on hcd_pkg and hcd_cfg_decode.
module hcd_parser #(
  parameter int unsigned MAX_BODY = 259,
  parameter int unsigned MAX_SEND = 255,
  parameter int unsigned MAX_TEXT = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output hcd_pkg::result_t res
);
  import hcd_pkg::*;

  localparam int unsigned LEN_W     = $clog2(MAX_BODY + 1);
  localparam logic [16:0] BODY_LIM  = 17'(MAX_BODY);
  localparam logic [16:0] SEND_LIM  = 17'(MAX_SEND);
  localparam logic [16:0] TEXT_LIM  = 17'(MAX_TEXT);
  localparam int unsigned HEAD_AW   = $clog2(HEAD_DEPTH);

  phase_t           phase, phase_next;
  cmd_t             command, command_next;
  logic [7:0]       length_low, length_low_next;
  logic             length_seen, length_seen_next;
  logic [LEN_W-1:0] body_length, body_length_next;
  logic [LEN_W-1:0] body_count, body_count_next;
  logic [7:0]       head [HEAD_DEPTH];
  logic [7:0]       head_eff [HEAD_DEPTH];

  logic [15:0]      len_full;
  logic             len_bad;
  logic [LEN_W-1:0] count_inc;
  logic             last;
  logic             in_head;
  logic [HEAD_AW-1:0] head_addr;
  logic [16:0]      len_ext;
  logic [16:0]      idx_ext;
  logic [16:0]      text_lim;
  logic             cfg_valid;
  result_t          cfg_res;

  // Length word and body position.
  assign len_full  = {rx_byte, length_low};
  assign len_bad   = (len_full == 16'd0) || (17'(len_full) > BODY_LIM);
  assign count_inc = body_count + LEN_W'(1);
  assign last      = count_inc >= body_length;
  assign in_head   = body_count < LEN_W'(HEAD_DEPTH);
  assign head_addr = body_count[HEAD_AW-1:0];
  assign len_ext   = 17'(body_length);
  assign idx_ext   = 17'(body_count);
  assign text_lim  = (len_ext < TEXT_LIM) ? len_ext : TEXT_LIM;

  // Head bytes as they stand once the current byte is written.
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_eff[i] = (in_head && head_addr == HEAD_AW'(i)) ? rx_byte : head[i];
    end
  end

  hcd_cfg_decode #(
    .LEN_W(LEN_W)
  ) u_cfg_decode (
    .head        (head_eff),
    .body_length (body_length),
    .valid       (cfg_valid),
    .res         (cfg_res)
  );

  // Next state and result for the byte on rx_byte.
  always_comb begin
    phase_next       = phase;
    command_next     = command;
    length_low_next  = length_low;
    length_seen_next = length_seen;
    body_length_next = body_length;
    body_count_next  = body_count;
    res_valid        = 1'b0;
    res              = '0;
    case (phase)
      PH_LEN: begin
        if (!length_seen) begin
          length_low_next  = rx_byte;
          length_seen_next = 1'b1;
        end else begin
          length_seen_next = 1'b0;
          body_count_next  = '0;
          if (len_bad) begin
            phase_next = PH_IDLE;
          end else begin
            body_length_next = LEN_W'(len_full);
            phase_next       = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_count_next = count_inc;
        case (command)
          FRAME_SEND: begin
            if (len_ext <= SEND_LIM) begin
              res_valid      = 1'b1;
              res.kind       = KIND_SEND;
              res.data_byte  = rx_byte;
              res.byte_index = 9'(body_count);
              res.last_byte  = last;
            end
          end
          FRAME_DISPLAY: begin
            if (idx_ext < text_lim) begin
              res_valid      = 1'b1;
              res.kind       = KIND_DISPLAY;
              res.data_byte  = rx_byte;
              res.byte_index = 9'(body_count);
              res.last_byte  = (idx_ext + 17'd1) == text_lim;
            end
          end
          FRAME_CONFIG: begin
            if (last && cfg_valid) begin
              res_valid = 1'b1;
              res       = cfg_res;
            end
          end
          default: begin
          end
        endcase
        if (last) begin
          phase_next      = PH_IDLE;
          body_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (rx_byte == CMD_BYTE_SEND || rx_byte == CMD_BYTE_CONFIG ||
            rx_byte == CMD_BYTE_DISPLAY) begin
          command_next     = cmd_t'(rx_byte[1:0]);
          phase_next       = PH_LEN;
          length_seen_next = 1'b0;
          body_count_next  = '0;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      command     <= FRAME_NONE;
      length_low  <= '0;
      length_seen <= 1'b0;
      body_length <= '0;
      body_count  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      command     <= command_next;
      length_low  <= length_low_next;
      length_seen <= length_seen_next;
      body_length <= body_length_next;
      body_count  <= body_count_next;
    end
  end

  // Leading body bytes of the current frame.
  always_ff @(posedge clk) begin
    if (take && phase == PH_BODY && in_head) begin
      head[head_addr] <= rx_byte;
    end
  end

  // A frame body never runs past its length.
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> body_count < body_length)
    else $error("body position past frame length");

  // Results only come out of a frame body.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == PH_BODY)
    else $error("result outside a frame body");

  // An oversized send frame never emits a byte.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_SEND) |-> len_ext <= SEND_LIM)
    else $error("byte emitted from an oversized send frame");

  // A bad length word sends the parser back to idle.
  assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_LEN && length_seen && len_bad) |=> phase == PH_IDLE)
    else $error("bad length did not return to idle");

endmodule

// ===== hw/rtl/hcd_out_reg.sv =====
// Result register: holds one result item until the downstream side takes it.
// Depends on hcd_pkg.
module hcd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             load_valid,
  input  hcd_pkg::result_t load_res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output hcd_pkg::result_t res
);
  import hcd_pkg::*;

  // The register can take a new item when empty or being emptied this cycle.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && load_valid) begin
      res <= load_res;
    end
  end

endmodule

// ===== hw/rtl/host_command_deframer_core.sv =====
// Host command deframer top level: byte input channel, parser and result register.
// Depends on hcd_pkg, hcd_parser and hcd_out_reg.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  rx_byte
//   output   out_valid/out_ready  kind, data_byte, byte_index, last_byte, freq_hz,
//                                 tx_power, bandwidth_khz, spread_factor,
//                                 coding_rate, preamble_len, crc_enable
//
// One byte is taken per cycle while in_ready is high; its result, if any, shows in the cycle after it is taken.
// The parser updates on the accepting edge, the result register decouples the sides.
// in_ready is low only while a result sits unaccepted and out_ready is low.
// Synchronous reset returns the parser to idle and empties the result register.
module host_command_deframer_core #(
  parameter int unsigned MAX_BODY = 259,
  parameter int unsigned MAX_SEND = 255,
  parameter int unsigned MAX_TEXT = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        data_byte,
  output logic [8:0]        byte_index,
  output logic              last_byte,
  output logic [31:0]       freq_hz,
  output logic signed [7:0] tx_power,
  output logic [8:0]        bandwidth_khz,
  output logic [7:0]        spread_factor,
  output logic [3:0]        coding_rate,
  output logic [7:0]        preamble_len,
  output logic              crc_enable
);
  import hcd_pkg::*;

  logic    take;
  logic    free;
  logic    res_valid;
  result_t parse_res;
  result_t out_res;

  assign in_ready = free;
  assign take     = in_valid && free;

  hcd_parser #(
    .MAX_BODY(MAX_BODY),
    .MAX_SEND(MAX_SEND),
    .MAX_TEXT(MAX_TEXT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (parse_res)
  );

  hcd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_valid (res_valid),
    .load_res   (parse_res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .free       (free),
    .res        (out_res)
  );

  // Result fields onto their ports.
  assign kind          = out_res.kind;
  assign data_byte     = out_res.data_byte;
  assign byte_index    = out_res.byte_index;
  assign last_byte     = out_res.last_byte;
  assign freq_hz       = out_res.freq_hz;
  assign tx_power      = out_res.tx_power;
  assign bandwidth_khz = out_res.bandwidth_khz;
  assign spread_factor = out_res.spread_factor;
  assign coding_rate   = out_res.coding_rate;
  assign preamble_len  = out_res.preamble_len;
  assign crc_enable    = out_res.crc_enable;

endmodule

// ===== tb/tb_host_command_deframer_core.sv =====
// Self-checking testbench for host_command_deframer_core: byte stream in, results out.
// Depends on hcd_pkg and the deframer RTL; an in-bench predictor checks every result transfer.
module tb_host_command_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hcd_pkg::*;

  localparam int unsigned BODY_MAX     = 259;
  localparam int unsigned SEND_MAX     = 255;
  localparam int unsigned TEXT_MAX     = 255;
  localparam int unsigned RANDOM_BYTES = 1725;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] wire_byte;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        data_byte;
  logic [8:0]        byte_index;
  logic              last_byte;
  logic [31:0]       freq_hz;
  logic signed [7:0] tx_power;
  logic [8:0]        bandwidth_khz;
  logic [7:0]        spread_factor;
  logic [3:0]        coding_rate;
  logic [7:0]        preamble_len;
  logic              crc_enable;

  // Predictor state of the frame parser.
  phase_t     ph       = PH_IDLE;
  cmd_t       cmd_q    = FRAME_NONE;
  logic [7:0] len_lo   = 8'h00;
  logic       len_seen = 1'b0;
  logic [8:0] body_len = 9'd0;
  logic [8:0] body_cnt = 9'd0;
  logic [7:0] head [HEAD_DEPTH];

  result_t     results_due [$];
  stim_row_t   opening_rows [$];
  int unsigned mismatches = 0;
  int unsigned in_calm    = 0;
  int unsigned out_calm   = 0;
  int unsigned idle_run   = 0;
  int unsigned stall;

  host_command_deframer_core #(
    .MAX_BODY(BODY_MAX),
    .MAX_SEND(SEND_MAX),
    .MAX_TEXT(TEXT_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .last_byte(last_byte),
    .freq_hz(freq_hz),
    .tx_power(tx_power),
    .bandwidth_khz(bandwidth_khz),
    .spread_factor(spread_factor),
    .coding_rate(coding_rate),
    .preamble_len(preamble_len),
    .crc_enable(crc_enable)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bandwidth and coding rate code mappings of the settings frames.
  function automatic logic [8:0] khz_for_code(input logic [7:0] code);
    if (code == 8'd1) return 9'd250;
    if (code == 8'd2) return 9'd500;
    return 9'd125;
  endfunction

  function automatic logic [3:0] rate_for_code(input logic [7:0] code);
    if (code >= 8'd1 && code <= 8'd4) return 4'(code + 8'd4);
    return 4'd5;
  endfunction

  // Decode the kept head bytes of a config body at its last byte.
  function automatic bit decode_settings(inout result_t r);
    logic [31:0] f;
    f = {head[5], head[4], head[3], head[2]};
    if (body_len < 9'd2) return 1'b0;
    if (head[0] == TAG_UPPER_T && head[1] == TAG_UPPER_C && body_len >= SETTINGS_MIN_LEN) begin
      r.kind          = KIND_TX_SET;
      r.freq_hz       = f;
      r.tx_power      = head[7];
      r.bandwidth_khz = khz_for_code(head[9]);
      r.spread_factor = head[10];
      r.coding_rate   = rate_for_code(head[11]);
      r.preamble_len  = head[12];
      r.crc_enable    = (head[14] != 8'd0);
      return 1'b1;
    end
    if (head[0] == TAG_UPPER_R && head[1] == TAG_UPPER_C && body_len >= SETTINGS_MIN_LEN) begin
      r.kind          = KIND_RX_SET;
      r.freq_hz       = f;
      r.bandwidth_khz = khz_for_code(head[7]);
      r.spread_factor = head[8];
      r.coding_rate   = rate_for_code(head[9]);
      r.preamble_len  = head[11];
      r.crc_enable    = (head[15] != 8'd0);
      return 1'b1;
    end
    if (head[0] == TAG_UPPER_T && head[1] == TAG_LOWER_C && body_len >= RETUNE_MIN_LEN) begin
      r.kind    = KIND_TX_RETUNE;
      r.freq_hz = f;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte causes a result.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [15:0] flen;
    int unsigned idx;
    int unsigned lim;
    bit          fin;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    case (ph)
      PH_LEN: begin
        if (!len_seen) begin
          len_lo   = b;
          len_seen = 1'b1;
        end else begin
          flen     = {b, len_lo};
          len_seen = 1'b0;
          body_cnt = 9'd0;
          if (flen == 16'd0 || flen > BODY_MAX) begin
            ph = PH_IDLE;
          end else begin
            body_len = flen[8:0];
            ph       = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        idx = 32'(body_cnt);
        if (idx < HEAD_DEPTH) head[4'(idx)] = b;
        body_cnt = 9'(idx + 1);
        fin      = (idx + 1 >= 32'(body_len));
        case (cmd_q)
          FRAME_SEND: begin
            if (body_len <= SEND_MAX) begin
              r.kind       = KIND_SEND;
              r.data_byte  = b;
              r.byte_index = 9'(idx);
              r.last_byte  = fin;
              hit          = 1'b1;
            end
          end
          FRAME_DISPLAY: begin
            lim = (32'(body_len) < TEXT_MAX) ? 32'(body_len) : TEXT_MAX;
            if (idx < lim) begin
              r.kind       = KIND_DISPLAY;
              r.data_byte  = b;
              r.byte_index = 9'(idx);
              r.last_byte  = (idx + 1 == lim);
              hit          = 1'b1;
            end
          end
          FRAME_CONFIG: begin
            if (fin) hit = decode_settings(r);
          end
          default: ;
        endcase
        if (fin) begin
          ph       = PH_IDLE;
          body_cnt = 9'd0;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves the same.
        ph = PH_IDLE;
        if (b == CMD_BYTE_SEND || b == CMD_BYTE_CONFIG || b == CMD_BYTE_DISPLAY) begin
          cmd_q    = cmd_t'(b[1:0]);
          ph       = PH_LEN;
          len_seen = 1'b0;
          body_cnt = 9'd0;
        end
      end
    endcase
    return hit;
  endfunction

  // Random wait before the next transfer, with stretches of no wait at all.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic result_t make_expect(input kind_t k, input logic [7:0] d,
                                          input logic [8:0] idx, input logic fin,
                                          input logic [31:0] f);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.data_byte  = d;
    r.byte_index = idx;
    r.last_byte  = fin;
    r.freq_hz    = f;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed = 1'b0,
                                  input result_t res = '0);
    stim_row_t row;
    row.wire_byte = b;
    row.typed     = typed;
    row.res       = res;
    opening_rows.push_back(row);
  endfunction

  // Body length of a send or display frame: mostly short, now and then near the maximum.
  function automatic int unsigned stream_length();
    if ($urandom_range(0, 29) == 0) return $urandom_range(BODY_MAX - 4, BODY_MAX);
    return $urandom_range(1, 12);
  endfunction

  // Config body length: mostly just above the minimum, sometimes short or long.
  function automatic int unsigned config_length(input int unsigned floor_len);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom_range(2, floor_len - 1);
    if (r == 2) return $urandom_range(floor_len, BODY_MAX);
    return floor_len + $urandom_range(0, 4);
  endfunction

  // Mapping codes are biased toward the decoded range.
  function automatic logic [7:0] code_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 5));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] tag_byte();
    case ($urandom_range(0, 4))
      0:       return TAG_UPPER_T;
      1:       return TAG_UPPER_R;
      2:       return TAG_UPPER_C;
      3:       return TAG_LOWER_C;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte, wait for its transfer, then record what it should produce.
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    int unsigned gap;
    result_t     predicted;
    bit          produced;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    produced = deframe_byte(b, predicted);
    if (typed) begin
      results_due.push_back(typed_res);
    end else if (produced) begin
      results_due.push_back(predicted);
    end
  endtask

  // Random frames: mostly well formed with random content, plus noise and bad lengths.
  task automatic run_random_traffic();
    logic [7:0]  body [$];
    logic [7:0]  cmd_b;
    logic [7:0]  stray;
    logic [15:0] flen;
    int unsigned pick;
    int unsigned flavor;
    int unsigned taken;
    int unsigned n;
    taken = 0;
    while (taken < RANDOM_BYTES) begin
      body.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        // Stray bytes in idle produce nothing but are still input items.
        n = $urandom_range(1, 3);
        repeat (n) begin
          do stray = 8'($urandom);
          while (stray >= CMD_BYTE_SEND && stray <= CMD_BYTE_DISPLAY);
          push_byte(stray);
        end
        taken += n;
      end else if (pick >= 80) begin
        // Header with a length outside 1..BODY_MAX.
        cmd_b = 8'($urandom_range(CMD_BYTE_SEND, CMD_BYTE_DISPLAY));
        case ($urandom_range(0, 3))
          0:       flen = 16'd0;
          1:       flen = 16'(BODY_MAX + 1);
          2:       flen = 16'hFFFF;
          default: flen = 16'($urandom_range(BODY_MAX + 1, 16'hFFFF));
        endcase
        push_byte(cmd_b);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        taken += 3;
      end else begin
        flavor = $urandom_range(0, 19);
        if (pick < 25) begin
          cmd_b = CMD_BYTE_SEND;
          flen  = 16'(stream_length());
        end else if (pick < 45) begin
          cmd_b = CMD_BYTE_DISPLAY;
          flen  = 16'(stream_length());
        end else begin
          cmd_b = CMD_BYTE_CONFIG;
          if (flavor < 14) begin
            flen = 16'(config_length(SETTINGS_MIN_LEN));
          end else if (flavor < 17) begin
            flen = 16'(config_length(RETUNE_MIN_LEN));
          end else begin
            flen = 16'($urandom_range(1, 24));
          end
        end
        repeat (flen) body.push_back(8'($urandom));
        if (cmd_b == CMD_BYTE_CONFIG) begin
          if (flen >= HEAD_DEPTH) begin
            body[7]  = code_byte();
            body[9]  = code_byte();
            body[11] = code_byte();
            body[14] = code_byte();
            body[15] = code_byte();
          end
          if (flavor < 7) begin
            body[0] = TAG_UPPER_T;
            body[1] = TAG_UPPER_C;
          end else if (flavor < 14) begin
            body[0] = TAG_UPPER_R;
            body[1] = TAG_UPPER_C;
          end else if (flavor < 17) begin
            body[0] = TAG_UPPER_T;
            body[1] = TAG_LOWER_C;
          end else begin
            body[0] = tag_byte();
            if (flen > 1) body[1] = tag_byte();
          end
        end
        push_byte(cmd_b);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        foreach (body[i]) push_byte(body[i]);
        taken += 3 + flen;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input result_t e);
    check_field("kind", 32'(e.kind), 32'(kind));
    check_field("data_byte", 32'(e.data_byte), 32'(data_byte));
    check_field("byte_index", 32'(e.byte_index), 32'(byte_index));
    check_field("last_byte", 32'(e.last_byte), 32'(last_byte));
    check_field("freq_hz", e.freq_hz, freq_hz);
    check_field("tx_power", 32'(e.tx_power), 32'(tx_power));
    check_field("bandwidth_khz", 32'(e.bandwidth_khz), 32'(bandwidth_khz));
    check_field("spread_factor", 32'(e.spread_factor), 32'(spread_factor));
    check_field("coding_rate", 32'(e.coding_rate), 32'(coding_rate));
    check_field("preamble_len", 32'(e.preamble_len), 32'(preamble_len));
    check_field("crc_enable", 32'(e.crc_enable), 32'(crc_enable));
  endtask

  // Result side: every transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: kind %0d", kind);
        mismatches++;
      end else begin
        compare_result(results_due.pop_front());
      end
    end
  end

  // Result side stalls: one random wait before each transfer.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) begin
        idle_run = 0;
      end else if (!rst) begin
        idle_run++;
      end
    end
    $display("tb_host_command_deframer_core NOT OK");
    $finish;
  end

  initial begin
    foreach (head[i]) head[i] = 8'h00;

    // Stray bytes at both extremes.
    add_row(8'h00);
    add_row(8'hFF);
    // Zero length drops back to idle.
    add_row(CMD_BYTE_SEND);
    add_row(8'h00);
    add_row(8'h00);
    // Length one above the maximum drops back to idle.
    add_row(CMD_BYTE_CONFIG);
    add_row(8'h04);
    add_row(8'h01);
    // One-byte send frame.
    add_row(CMD_BYTE_SEND);
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'hFF, 1'b1, make_expect(KIND_SEND, 8'hFF, 9'd0, 1'b1, 32'd0));
    // Two-byte display frame.
    add_row(CMD_BYTE_DISPLAY);
    add_row(8'h02);
    add_row(8'h00);
    add_row(8'h00, 1'b1, make_expect(KIND_DISPLAY, 8'h00, 9'd0, 1'b0, 32'd0));
    add_row(8'hFF, 1'b1, make_expect(KIND_DISPLAY, 8'hFF, 9'd1, 1'b1, 32'd0));
    // Shortest tx retune frame.
    add_row(CMD_BYTE_CONFIG);
    add_row(8'h06);
    add_row(8'h00);
    add_row(TAG_UPPER_T);
    add_row(TAG_LOWER_C);
    add_row(8'h78);
    add_row(8'h56);
    add_row(8'h34);
    add_row(8'h12, 1'b1, make_expect(KIND_TX_RETUNE, 8'h00, 9'd0, 1'b0, 32'h12345678));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      push_byte(opening_rows[i].wire_byte, opening_rows[i].typed, opening_rows[i].res);
    end
    run_random_traffic();
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_host_command_deframer_core OK");
    end else begin
      $display("tb_host_command_deframer_core NOT OK");
    end
    $finish;
  end

endmodule
